/* rtl/core/sbpe_pkg.sv */
// Shared constants, widths, codes and datapath control struct for the
// sparse bivariate polynomial evaluator. No dependencies.
package sbpe_pkg;

	localparam int MAX_DEGREE = 3;
	localparam int FRAC_BITS  = 8;
	localparam int COEF_SLOTS = 16;

	localparam int COEF_W   = 32;
	localparam int VAR_W    = 16;
	localparam int IDX_W    = 4;
	localparam int VALUE_W  = 48;
	localparam int MAP_W    = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam int LIMB_W  = 32;
	localparam int LIMBS   = MAX_DEGREE + 1;
	localparam int L_W     = $clog2(LIMBS);
	localparam int PROD_W  = LIMB_W * LIMBS;
	localparam int MUL_W   = LIMB_W + VAR_W;
	localparam int ACC_W   = PROD_W + 5;
	localparam int SCALE   = 2 * MAX_DEGREE * FRAC_BITS;
	localparam int SH_W    = (SCALE > 0) ? $clog2(SCALE + 1) : 1;

	localparam int D_W     = $clog2(MAX_DEGREE + 1);
	localparam int T_RAW   = $clog2((MAX_DEGREE + 1) * (MAX_DEGREE + 1) + 1);
	localparam int T_W     = (T_RAW > 5) ? T_RAW : 5;
	localparam int SLOT_W  = (COEF_SLOTS > 1) ? $clog2(COEF_SLOTS) : 1;
	localparam int A_W     = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
	localparam int K_W     = (SLOT_W + 1 > 5) ? SLOT_W + 1 : 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_INNER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_OUTER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MAP  = 2'd3;

	localparam logic [1:0] VARS_NONE = 2'd0;
	localparam logic [1:0] VARS_ONE  = 2'd1;

	typedef struct packed {
		logic            clear_acc;
		logic            load_prod;
		logic            mul_en;
		logic            mul_sel_y;
		logic [L_W-1:0]  limb;
		logic            add_en;
		logic [SH_W-1:0] shamt;
		logic            round_en;
	} dp_ctrl_t;

endpackage

/* rtl/core/sbpe_coef_store.sv */
// Packed coefficient table, one write and one registered read port.
// Depends on sbpe_pkg.
module sbpe_coef_store (
	input  logic                            clk,
	input  logic                            we,
	input  logic [sbpe_pkg::A_W-1:0]        wr_addr,
	input  logic signed [sbpe_pkg::COEF_W-1:0] wr_data,
	input  logic [sbpe_pkg::A_W-1:0]        rd_addr,
	output logic signed [sbpe_pkg::COEF_W-1:0] rd_data
);
	import sbpe_pkg::*;

	logic signed [COEF_W-1:0] mem_q [COEF_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr[SLOT_W-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr[SLOT_W-1:0]];
	end

endmodule

/* rtl/core/sbpe_datapath.sv */
// Shared limb multiplier, term product register and exact accumulator,
// with rounding and saturation of the final sum. Depends on sbpe_pkg.
module sbpe_datapath (
	input  logic                               clk,
	input  sbpe_pkg::dp_ctrl_t                 ctrl,
	input  logic signed [sbpe_pkg::COEF_W-1:0] coef,
	input  logic [sbpe_pkg::VAR_W-1:0]         inner_var,
	input  logic [sbpe_pkg::VAR_W-1:0]         outer_var,
	output logic signed [sbpe_pkg::VALUE_W-1:0] res_value,
	output logic                               res_sat
);
	import sbpe_pkg::*;

	localparam logic [ACC_W-1:0] ROUND_ADD =
		(SCALE > 0) ? (ACC_W'(1) << ((SCALE > 0) ? SCALE - 1 : 0)) : '0;
	localparam int TOP_LO = SCALE + VALUE_W - 1;

	logic [PROD_W-1:0]       prod_q;
	logic [VAR_W-1:0]        carry_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [LIMB_W-1:0] mul_limb;
	logic [VAR_W-1:0]  mul_op;
	logic [VAR_W-1:0]  carry_in;
	logic [MUL_W-1:0]  mul_p;
	logic [ACC_W-1:0]  term_ext;
	logic [ACC_W-1:0]  term_sh;
	logic              sign;

	always_comb begin
		mul_limb = prod_q[ctrl.limb * LIMB_W +: LIMB_W];
		mul_op   = ctrl.mul_sel_y ? outer_var : inner_var;
		carry_in = (ctrl.limb == '0) ? '0 : carry_q;
		mul_p    = MUL_W'(mul_limb) * MUL_W'(mul_op) + MUL_W'(carry_in);
		term_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
		term_sh  = term_ext << ctrl.shamt;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_prod) begin
			prod_q <= {{(PROD_W - COEF_W){coef[COEF_W-1]}}, coef};
		end else if (ctrl.mul_en) begin
			prod_q[ctrl.limb * LIMB_W +: LIMB_W] <= mul_p[LIMB_W-1:0];
			carry_q <= mul_p[MUL_W-1:LIMB_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear_acc) begin
			acc_q <= '0;
		end else if (ctrl.add_en) begin
			acc_q <= acc_q + signed'(term_sh);
		end else if (ctrl.round_en) begin
			acc_q <= acc_q + signed'(ROUND_ADD);
		end
	end

	always_comb begin
		sign    = acc_q[ACC_W-1];
		res_sat = acc_q[ACC_W-1:TOP_LO] != {(ACC_W - TOP_LO){sign}};
		if (res_sat) begin
			res_value = sign ? {1'b1, {(VALUE_W - 1){1'b0}}} : {1'b0, {(VALUE_W - 1){1'b1}}};
		end else begin
			res_value = acc_q[TOP_LO:SCALE];
		end
	end

endmodule

/* rtl/core/sparse_bivariate_polynomial_eval.sv */
// Sparse bivariate polynomial evaluator: a coefficient write is stored when
// it is accepted. An evaluate visits each term in turn; a present term loads
// its coefficient, has each power of a variable applied to it limb by limb
// on the shared 32x16 limb multiplier and is added to the accumulator; the
// sum is then rounded and registered for output. The block is not ready
// while an evaluate runs. Depends on sbpe_pkg, sbpe_coef_store and
// sbpe_datapath.
module sparse_bivariate_polynomial_eval (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sbpe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sbpe_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [sbpe_pkg::IDX_W-1:0]           coef_index,
	input  logic signed [sbpe_pkg::COEF_W-1:0]   coef_value,
	input  logic [sbpe_pkg::VAR_W-1:0]           inner_var,
	input  logic [sbpe_pkg::VAR_W-1:0]           outer_var,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [sbpe_pkg::VALUE_W-1:0]  value,
	output logic                                 saturated
);
	import sbpe_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_TERM  = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_ADD   = 6'b001000,
		ST_ROUND = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [1:0]       var_count_q;
	logic [1:0]       degree_inner_q;
	logic [1:0]       degree_outer_q;
	logic [MAP_W-1:0] present_map_q;

	logic [VAR_W-1:0] x_q, y_q;
	logic [D_W-1:0]   din_q, dout_q, po_q, pi_q, ny_q, nx_q;
	logic [L_W-1:0]   limb_q;
	logic [T_W-1:0]   t_q;
	logic [K_W-1:0]   k_q;

	logic                     in_beat;
	logic                     store_we;
	logic signed [COEF_W-1:0] rd_data;
	logic signed [COEF_W-1:0] coef;
	logic                     present;
	logic                     last_inner, last_term, last_limb;
	logic [D_W-1:0]           din_d, dout_d;
	dp_ctrl_t                 ctrl;
	logic signed [VALUE_W-1:0] res_value;
	logic                     res_sat;

	function automatic logic [D_W-1:0] clamp_deg(input logic [1:0] d);
		if (int'(d) > MAX_DEGREE) begin
			return D_W'(MAX_DEGREE);
		end
		return D_W'(d);
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign store_we = in_beat && (op == OP_WRITE) && (int'(coef_index) < COEF_SLOTS);

	sbpe_coef_store u_store (
		.clk     (clk),
		.we      (store_we),
		.wr_addr (A_W'(coef_index)),
		.wr_data (coef_value),
		.rd_addr (A_W'(k_q)),
		.rd_data (rd_data)
	);

	always_comb begin
		coef       = (int'(k_q) < COEF_SLOTS) ? rd_data : '0;
		present    = (t_q < T_W'(MAP_W)) && present_map_q[t_q[3:0]];
		last_inner = (pi_q == din_q);
		last_term  = last_inner && (po_q == dout_q);
		last_limb  = (int'(limb_q) == LIMBS - 1);
		unique case (var_count_q)
			VARS_NONE: begin
				dout_d = '0;
				din_d  = '0;
			end
			VARS_ONE: begin
				dout_d = clamp_deg(degree_inner_q);
				din_d  = '0;
			end
			default: begin
				dout_d = clamp_deg(degree_outer_q);
				din_d  = clamp_deg(degree_inner_q);
			end
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.clear_acc = in_beat && (op == OP_EVAL);
		ctrl.load_prod = (state_q == ST_TERM) && present;
		ctrl.mul_en    = (state_q == ST_MUL);
		ctrl.mul_sel_y = (ny_q != '0);
		ctrl.limb      = limb_q;
		ctrl.add_en    = (state_q == ST_ADD);
		ctrl.shamt     = SH_W'(FRAC_BITS * (2 * MAX_DEGREE - int'(po_q) - int'(pi_q)));
		ctrl.round_en  = (state_q == ST_ROUND);
	end

	sbpe_datapath u_dp (
		.clk       (clk),
		.ctrl      (ctrl),
		.coef      (coef),
		.inner_var (x_q),
		.outer_var (y_q),
		.res_value (res_value),
		.res_sat   (res_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q    <= '0;
			degree_inner_q <= '0;
			degree_outer_q <= '0;
			present_map_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VAR_COUNT:    var_count_q    <= cfg_data[1:0];
				CFG_DEGREE_INNER: degree_inner_q <= cfg_data[1:0];
				CFG_DEGREE_OUTER: degree_outer_q <= cfg_data[1:0];
				CFG_PRESENT_MAP:  present_map_q  <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && (op == OP_EVAL)) begin
			x_q <= inner_var;
			y_q <= outer_var;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			din_q     <= '0;
			dout_q    <= '0;
			po_q      <= '0;
			pi_q      <= '0;
			ny_q      <= '0;
			nx_q      <= '0;
			limb_q    <= '0;
			t_q       <= '0;
			k_q       <= '0;
			out_valid <= 1'b0;
			value     <= '0;
			saturated <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && (op == OP_EVAL)) begin
						din_q   <= din_d;
						dout_q  <= dout_d;
						po_q    <= '0;
						pi_q    <= '0;
						t_q     <= '0;
						k_q     <= '0;
						state_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					if (present) begin
						k_q    <= k_q + K_W'(1);
						ny_q   <= po_q;
						nx_q   <= pi_q;
						limb_q <= '0;
						state_q <= ((po_q == '0) && (pi_q == '0)) ? ST_ADD : ST_MUL;
					end else begin
						t_q <= t_q + T_W'(1);
						if (last_term) begin
							state_q <= ST_ROUND;
						end else if (last_inner) begin
							po_q <= po_q + D_W'(1);
							pi_q <= '0;
						end else begin
							pi_q <= pi_q + D_W'(1);
						end
					end
				end
				ST_MUL: begin
					if (last_limb) begin
						limb_q <= '0;
						if (ny_q != '0) begin
							ny_q <= ny_q - D_W'(1);
							if ((ny_q == D_W'(1)) && (nx_q == '0)) begin
								state_q <= ST_ADD;
							end
						end else begin
							nx_q <= nx_q - D_W'(1);
							if (nx_q == D_W'(1)) begin
								state_q <= ST_ADD;
							end
						end
					end else begin
						limb_q <= limb_q + L_W'(1);
					end
				end
				ST_ADD: begin
					t_q <= t_q + T_W'(1);
					if (last_term) begin
						state_q <= ST_ROUND;
					end else begin
						state_q <= ST_TERM;
						if (last_inner) begin
							po_q <= po_q + D_W'(1);
							pi_q <= '0;
						end else begin
							pi_q <= pi_q + D_W'(1);
						end
					end
				end
				ST_ROUND: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						value     <= res_value;
						saturated <= res_sat;
						k_q       <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* bench/tb_poly_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the sparse polynomial evaluator bench: mirrors the coefficient
// table and the four registers and predicts every evaluate with exact wide sums.
// Depends on sbpe_pkg.
package tb_poly_pkg;
	import sbpe_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               sat;
	} poly_result_t;

	class poly_score;
		logic [COEF_W-1:0] coef_mirror [COEF_SLOTS];
		logic [1:0]        var_cnt;
		logic [1:0]        deg_in;
		logic [1:0]        deg_out;
		logic [MAP_W-1:0]  term_map;
		poly_result_t      due_values [$];
		int                errors;

		function new();
			foreach (coef_mirror[i]) coef_mirror[i] = '0;
			var_cnt  = '0;
			deg_in   = '0;
			deg_out  = '0;
			term_map = '0;
			errors   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_VAR_COUNT:    var_cnt  = data[1:0];
				CFG_DEGREE_INNER: deg_in   = data[1:0];
				CFG_DEGREE_OUTER: deg_out  = data[1:0];
				CFG_PRESENT_MAP:  term_map = data[MAP_W-1:0];
				default: ;
			endcase
		endfunction

		function void accept_item(logic opc, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] cval,
				logic [VAR_W-1:0] x, logic [VAR_W-1:0] y);
			logic signed [159:0] sum, term, xw, yw, lim_hi, lim_lo;
			poly_result_t res;
			int n_out, n_in, slot, t, scale;
			if (opc == OP_WRITE) begin
				if (idx < COEF_SLOTS) coef_mirror[idx] = cval;
				return;
			end
			scale = 2 * MAX_DEGREE * FRAC_BITS;
			n_out = (var_cnt == VARS_NONE) ? 0 : (var_cnt == VARS_ONE) ? int'(deg_in) : int'(deg_out);
			n_in  = (var_cnt == VARS_NONE || var_cnt == VARS_ONE) ? 0 : int'(deg_in);
			if (n_out > MAX_DEGREE) n_out = MAX_DEGREE;
			if (n_in > MAX_DEGREE) n_in = MAX_DEGREE;
			xw   = x;
			yw   = y;
			sum  = '0;
			slot = 0;
			// outer power outside, inner power inside; present terms take packed slots
			for (int po = 0; po <= n_out; po++) begin
				for (int pw = 0; pw <= n_in; pw++) begin
					t = po * (n_in + 1) + pw;
					if (t < MAP_W && term_map[t]) begin
						term = (slot < COEF_SLOTS) ? $signed(coef_mirror[slot]) : 0;
						repeat (po) term = term * yw;
						repeat (pw) term = term * xw;
						term = term <<< (FRAC_BITS * (2 * MAX_DEGREE - po - pw));
						sum  = sum + term;
						slot++;
					end
				end
			end
			// add half, then floor
			if (scale > 0) sum = sum + (160'sd1 <<< (scale - 1));
			sum    = sum >>> scale;
			lim_hi = (160'sd1 <<< (VALUE_W - 1)) - 160'sd1;
			lim_lo = -(160'sd1 <<< (VALUE_W - 1));
			if (sum > lim_hi) begin
				res.value = lim_hi[VALUE_W-1:0];
				res.sat   = 1'b1;
			end else if (sum < lim_lo) begin
				res.value = lim_lo[VALUE_W-1:0];
				res.sat   = 1'b1;
			end else begin
				res.value = sum[VALUE_W-1:0];
				res.sat   = 1'b0;
			end
			due_values.push_back(res);
		endfunction

		function void check_result(logic [VALUE_W-1:0] got_value, logic got_sat);
			poly_result_t want;
			if (due_values.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: value=%h saturated=%b", got_value, got_sat);
				return;
			end
			want = due_values.pop_front();
			if (got_value !== want.value || got_sat !== want.sat) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: value exp %h got %h, saturated exp %b got %b",
						want.value, got_value, want.sat, got_sat);
			end
		endfunction
	endclass

endpackage

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Bench top for sparse_bivariate_polynomial_eval: drives coefficient writes, evaluates
// and register settings under random idling and checks each result beat.
// Depends on sbpe_pkg, tb_poly_pkg and the block's RTL.
module tb_top;
	import sbpe_pkg::*;
	import tb_poly_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 300;
	localparam int HOLD_CYCLES = 500;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 72;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       op;
	logic [IDX_W-1:0]           coef_index;
	logic signed [COEF_W-1:0]   coef_value;
	logic [VAR_W-1:0]           inner_var;
	logic [VAR_W-1:0]           outer_var;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [VALUE_W-1:0]  value;
	logic                       saturated;

	poly_score sb;
	int        send_idle_pct;
	int        recv_idle_pct;
	logic      hold_request;

	sparse_bivariate_polynomial_eval u_top (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [VAR_W-1:0] pick_var();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2, 3: return VAR_W'($urandom_range(16'h01FF));
			default: return VAR_W'($urandom());
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return COEF_W'($urandom_range(20'hFFFFF));
			3: return -COEF_W'($urandom_range(20'hFFFFF));
			default: return $urandom();
		endcase
	endfunction

	task automatic send_beat(logic o, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] cv,
			logic [VAR_W-1:0] x, logic [VAR_W-1:0] y);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		coef_index <= idx;
		coef_value <= cv;
		inner_var  <= x;
		outer_var  <= y;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		sb.accept_item(o, idx, cv, x, y);
	endtask

	task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
	endtask

	task automatic apply_setting(logic [1:0] vc, logic [1:0] di, logic [1:0] dw,
			logic [MAP_W-1:0] map);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_values.size() != 0) @(posedge clk);
		// let a trailing coefficient write retire
		repeat (8) @(posedge clk);
		poke_reg(CFG_VAR_COUNT, CFG_W'(vc));
		poke_reg(CFG_DEGREE_INNER, CFG_W'(di));
		poke_reg(CFG_DEGREE_OUTER, CFG_W'(dw));
		poke_reg(CFG_PRESENT_MAP, CFG_W'(map));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: random stalls plus one long hold-off on request
	initial begin : recv_proc
		int   hold_left;
		logic hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_left  = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watch_proc
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_result(value, saturated);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : main_proc
		logic o;
		sb            = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_VAR_COUNT;
		cfg_data      = '0;
		in_valid      = 1'b0;
		op            = OP_WRITE;
		coef_index    = '0;
		coef_value    = '0;
		inner_var     = '0;
		outer_var     = '0;
		send_idle_pct = 29;
		recv_idle_pct = 81;
		hold_request  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill every slot so no evaluate reads an unwritten entry
		apply_setting(2'd2, 2'd3, 2'd3, 16'hFFFF);
		for (int i = 0; i < COEF_SLOTS; i++)
			send_beat(OP_WRITE, IDX_W'(i), 32'h7FFF_FFFF, '0, '0);
		send_beat(OP_EVAL, '0, '0, 16'hFFFF, 16'hFFFF);
		send_beat(OP_EVAL, '1, '1, '0, '0);
		send_beat(OP_WRITE, '0, 32'h8000_0000, '1, '1);
		// drive the top term alone to saturate low
		apply_setting(2'd2, 2'd3, 2'd3, 16'h8000);
		send_beat(OP_EVAL, '0, '0, 16'hFFFF, 16'hFFFF);
		// exact half on one term: round up from both signs
		send_beat(OP_WRITE, '0, 32'h0000_0001, '0, '0);
		apply_setting(VARS_ONE, 2'd1, 2'd0, 16'h0002);
		send_beat(OP_EVAL, '0, '0, 16'h1234, 16'h0080);
		send_beat(OP_WRITE, '0, 32'hFFFF_FFFF, '0, '0);
		send_beat(OP_EVAL, '0, '0, 16'h1234, 16'h0080);
		// variable count three behaves as two
		apply_setting(2'd3, 2'd2, 2'd1, 16'h0FFF);
		send_beat(OP_EVAL, '0, '0, 16'h0100, 16'h0100);

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = (ph < 3) ? 29 : (ph < 6) ? 81 : 0;
			recv_idle_pct = (ph < 3) ? 81 : (ph < 6) ? 29 : 0;
			case (ph)
				0: apply_setting(2'd2, 2'd3, 2'd3, 16'hFFFF);
				1: apply_setting(VARS_NONE, 2'd0, 2'd0, 16'h0000);
				2: apply_setting(VARS_ONE, 2'd3, 2'd0, MAP_W'($urandom()));
				3: apply_setting(2'd3, 2'd3, 2'd3, MAP_W'($urandom()));
				4: apply_setting(2'd2, 2'd0, 2'd3, MAP_W'($urandom()));
				5: apply_setting(2'd2, 2'd3, 2'd0, MAP_W'($urandom()));
				6: apply_setting(2'd2, 2'd3, 2'd3, 16'hFFFF);
				7: apply_setting(2'($urandom_range(3)), 2'($urandom_range(3)),
					2'($urandom_range(3)), MAP_W'($urandom()));
				default: apply_setting(VARS_ONE, 2'd0, 2'd0, 16'hFFFF);
			endcase
			// hold the result side off while items keep coming
			if (ph == 6) hold_request = 1'b1;
			repeat (PHASE_ITEMS) begin
				o = ($urandom_range(99) < 40) ? OP_WRITE : OP_EVAL;
				send_beat(o, IDX_W'($urandom_range(COEF_SLOTS - 1)), pick_coef(),
					pick_var(), pick_var());
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_values.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
